// ===== hdl/multi_pattern_trie_matcher_defines.svh =====
// Assertion macros for the multi-pattern trie matcher.
// Depends on nothing; taken in by the top level. SYNTH empties the bodies.
`ifndef MULTI_PATTERN_TRIE_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_TRIE_MATCHER_DEFINES_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge out of reset.
`define MPTM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mptm assertion failed");
// A cause that must be followed by an effect in the next cycle.
`define MPTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mptm assertion failed");
`else
`define MPTM_ASSERT(lbl, cond)
`define MPTM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mptm_pkg.sv =====
// Shared types and constants of the multi-pattern trie matcher.
// Used by the node scanner and the top level; depends on nothing.
package mptm_pkg;

    localparam int NODES_DEF = 256;

    typedef struct packed {
        logic       op;
        logic [7:0] symbol;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        logic match;
        logic dropped;
    } t_result;

    typedef struct packed {
        logic start;
        logic use_sym;
    } t_scan_cmd;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SCAN   = 1'b1;

endpackage

// ===== hdl/mptm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mptm_scan.sv =====
// Node scanner: walks the parent and symbol tables one node at a time (bound check,
// then compare) looking for a child of a given node. Depends on mptm_pkg and mptm_ram.
module mptm_scan import mptm_pkg::*; #(
    parameter int NODES = NODES_DEF,
    localparam int IW = $clog2(NODES),
    localparam int CW = $clog2(NODES + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scan_cmd  i_cmd,
    input  logic [IW-1:0] i_key_parent,
    input  logic [7:0] i_key_symbol,
    input  logic [CW-1:0] i_from,
    input  logic [CW-1:0] i_count,
    input  logic       i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [IW-1:0] i_wr_parent,
    input  logic [7:0] i_wr_symbol,
    output t_scan_stat o_stat,
    output logic [IW-1:0] o_node,
    output logic [7:0] o_node_symbol
);

    logic          r_busy, n_busy;
    logic          r_cmp, n_cmp;
    logic [CW-1:0] r_v, n_v;
    logic [IW-1:0] r_kp, n_kp;
    logic [7:0]    r_ks, n_ks;
    logic          r_use, n_use;
    logic [IW-1:0] parent_rd;
    logic [7:0]    symbol_rd;

    mptm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_parent (
        .i_clk(i_clk), .i_we(i_wr_en), .i_waddr(i_wr_addr), .i_wdata(i_wr_parent),
        .i_raddr(r_v[IW-1:0]), .o_rdata(parent_rd)
    );

    mptm_ram #(.WIDTH(8), .DEPTH(NODES)) u_symbol (
        .i_clk(i_clk), .i_we(i_wr_en), .i_waddr(i_wr_addr), .i_wdata(i_wr_symbol),
        .i_raddr(r_v[IW-1:0]), .o_rdata(symbol_rd)
    );

    always_comb begin
        n_busy = r_busy;
        n_cmp  = r_cmp;
        n_v    = r_v;
        n_kp   = r_kp;
        n_ks   = r_ks;
        n_use  = r_use;
        o_stat = '0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cmp  = 1'b0;
            n_v    = i_from;
            n_kp   = i_key_parent;
            n_ks   = i_key_symbol;
            n_use  = i_cmd.use_sym;
        end else if (r_busy && !r_cmp) begin
            if (r_v >= i_count) begin
                o_stat.done = 1'b1;
                n_busy      = 1'b0;
            end else begin
                n_cmp = 1'b1;
            end
        end else if (r_busy) begin
            if (parent_rd == r_kp && (!r_use || symbol_rd == r_ks)) begin
                o_stat.done = 1'b1;
                o_stat.hit  = 1'b1;
                n_busy      = 1'b0;
            end else begin
                n_v   = r_v + CW'(1);
                n_cmp = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cmp  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cmp  <= n_cmp;
        end
        r_v   <= n_v;
        r_kp  <= n_kp;
        r_ks  <= n_ks;
        r_use <= n_use;
    end

    assign o_node        = r_v[IW-1:0];
    assign o_node_symbol = symbol_rd;

endmodule

// ===== hdl/multi_pattern_trie_matcher.sv =====
// Top level of the multi-pattern trie matcher (Aho-Corasick automaton).
// Depends on mptm_pkg, mptm_ram, mptm_scan and the assertion macro header.
//
// Usage. A word is offered on i_item with start high; it is taken at the
// rising edge where start is high and busy is low. A pattern word (op 0)
// extends the trie by at most one node; a text word (op 1) moves the scan
// through goto and failure transitions. Exactly one result word follows
// each input word: o_strobe is high for one cycle with o_result, and the
// receiver must take it then, as it cannot hold results off.
// Timing. All lookups go through one node scanner, which tests one stored
// node at a time, so the node count N sets the pace. A pattern word needs
// at most one scan, its result appearing after that scan ends. A text word
// needs one scan for each goto or failure step plus a read of the terminal
// and failure tables for each dictionary-chain step. The first text word
// after reset or after the trie has grown also rebuilds every failure link
// in breadth-first order, scanning for the children of each node.
// Reset. A synchronous, active-low reset leaves only the root in the trie,
// marks the failure links stale and returns both walks to the root. No
// clearing pass is needed: only nodes below the count are ever read.
`include "multi_pattern_trie_matcher_defines.svh"

module multi_pattern_trie_matcher import mptm_pkg::*; #(
    parameter int NODES = NODES_DEF,
    localparam int IW = $clog2(NODES),
    localparam int CW = $clog2(NODES + 1)
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS     = 4'd1;
    localparam logic [3:0] ST_INS_W   = 4'd2;
    localparam logic [3:0] ST_TXT     = 4'd3;
    localparam logic [3:0] ST_RB_INIT = 4'd4;
    localparam logic [3:0] ST_RB_POP  = 4'd5;
    localparam logic [3:0] ST_RB_QW   = 4'd6;
    localparam logic [3:0] ST_RB_SCAN = 4'd7;
    localparam logic [3:0] ST_RB_SW   = 4'd8;
    localparam logic [3:0] ST_RB_FU   = 4'd9;
    localparam logic [3:0] ST_ADV_CH  = 4'd10;
    localparam logic [3:0] ST_ADV_W   = 4'd11;
    localparam logic [3:0] ST_ADV_F   = 4'd12;
    localparam logic [3:0] ST_MC_CHK  = 4'd13;
    localparam logic [3:0] ST_MC_W    = 4'd14;

    // Where a transition lookup hands its answer back.
    localparam logic RET_REBUILD = 1'b0;
    localparam logic RET_TEXT    = 1'b1;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_ipos, n_ipos;
    logic          r_idrop, n_idrop;
    logic [IW-1:0] r_spos, n_spos;
    logic          r_tm, n_tm;
    logic          r_stale, n_stale;
    t_item         r_item, n_item;
    logic [IW-1:0] r_x, n_x;
    logic [7:0]    r_c, n_c;
    logic [IW-1:0] r_u, n_u;
    logic [IW-1:0] r_v, n_v;
    logic [CW-1:0] r_from, n_from;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_tail, n_tail;
    logic          r_ret, n_ret;
    logic [IW-1:0] r_j, n_j;
    logic          r_strobe, n_strobe;
    t_result       r_out, n_out;

    // Scanner and table ports.
    t_scan_cmd     scan_cmd;
    t_scan_stat    scan_stat;
    logic [IW-1:0] scan_key_p;
    logic [7:0]    scan_key_s;
    logic [CW-1:0] scan_from;
    logic [IW-1:0] scan_node;
    logic [7:0]    scan_node_sym;
    logic          node_we;
    logic          term_we, term_wd, term_rd;
    logic [IW-1:0] term_wa;
    logic          fail_we;
    logic [IW-1:0] fail_wa, fail_wd, fail_ra, fail_rd;
    logic          q_we;
    logic [IW-1:0] q_wa, q_wd, q_rd;
    logic [IW-1:0] adv_val;

    mptm_scan #(.NODES(NODES)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(scan_cmd),
        .i_key_parent(scan_key_p), .i_key_symbol(scan_key_s), .i_from(scan_from),
        .i_count(r_count), .i_wr_en(node_we), .i_wr_addr(r_count[IW-1:0]),
        .i_wr_parent(r_ipos), .i_wr_symbol(r_item.symbol),
        .o_stat(scan_stat), .o_node(scan_node), .o_node_symbol(scan_node_sym)
    );

    mptm_ram #(.WIDTH(1), .DEPTH(NODES)) u_term (
        .i_clk(i_clk), .i_we(term_we), .i_waddr(term_wa), .i_wdata(term_wd),
        .i_raddr(r_j), .o_rdata(term_rd)
    );

    mptm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_fail (
        .i_clk(i_clk), .i_we(fail_we), .i_waddr(fail_wa), .i_wdata(fail_wd),
        .i_raddr(fail_ra), .o_rdata(fail_rd)
    );

    mptm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(r_head[IW-1:0]), .o_rdata(q_rd)
    );

    // Answer of a transition lookup once the scan for the child has ended.
    assign adv_val = scan_stat.hit ? scan_node : '0;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ipos   = r_ipos;
        n_idrop  = r_idrop;
        n_spos   = r_spos;
        n_tm     = r_tm;
        n_stale  = r_stale;
        n_item   = r_item;
        n_x      = r_x;
        n_c      = r_c;
        n_u      = r_u;
        n_v      = r_v;
        n_from   = r_from;
        n_head   = r_head;
        n_tail   = r_tail;
        n_ret    = r_ret;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_out    = r_out;

        scan_cmd   = '0;
        scan_key_p = r_x;
        scan_key_s = r_c;
        scan_from  = CW'(1);
        node_we    = 1'b0;
        term_we    = 1'b0;
        term_wa    = r_ipos;
        term_wd    = 1'b1;
        fail_we    = 1'b0;
        fail_wa    = r_v;
        fail_wd    = adv_val;
        fail_ra    = r_x;
        q_we       = 1'b0;
        q_wa       = r_tail[IW-1:0];
        q_wd       = scan_node;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.op == OP_INSERT) begin
                        n_state = ST_INS;
                        if (i_item.first) begin
                            n_ipos  = '0;
                            n_idrop = 1'b0;
                        end
                    end else begin
                        n_state = ST_TXT;
                        if (i_item.first) begin
                            n_spos = '0;
                            n_tm   = 1'b0;
                        end
                    end
                end
            end
            ST_INS: begin
                if (r_idrop) begin
                    // A pattern that overflowed the table is dropped to its end.
                    n_out    = '{match: 1'b0, dropped: 1'b1};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_item.last) begin
                        n_ipos  = '0;
                        n_idrop = 1'b0;
                    end
                end else begin
                    scan_cmd   = '{start: 1'b1, use_sym: 1'b1};
                    scan_key_p = r_ipos;
                    scan_key_s = r_item.symbol;
                    n_state    = ST_INS_W;
                end
            end
            ST_INS_W: begin
                if (scan_stat.done) begin
                    n_out    = '{match: 1'b0, dropped: 1'b0};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                    if (scan_stat.hit) begin
                        n_ipos  = scan_node;
                        term_wa = scan_node;
                        term_we = r_item.last;
                    end else if (r_count < CW'(NODES)) begin
                        // New node: its terminal flag is written in the same go.
                        node_we = 1'b1;
                        term_we = 1'b1;
                        term_wa = r_count[IW-1:0];
                        term_wd = r_item.last;
                        n_ipos  = r_count[IW-1:0];
                        n_count = r_count + CW'(1);
                        n_stale = 1'b1;
                    end else begin
                        n_idrop       = 1'b1;
                        n_out.dropped = 1'b1;
                    end
                    if (r_item.last) begin
                        n_ipos  = '0;
                        n_idrop = 1'b0;
                    end
                end
            end
            ST_TXT: begin
                if (r_stale) begin
                    n_state = ST_RB_INIT;
                end else begin
                    n_x     = r_spos;
                    n_c     = r_item.symbol;
                    n_ret   = RET_TEXT;
                    n_state = ST_ADV_CH;
                end
            end
            ST_RB_INIT: begin
                q_we    = 1'b1;
                q_wa    = '0;
                q_wd    = '0;
                n_head  = '0;
                n_tail  = CW'(1);
                n_state = ST_RB_POP;
            end
            ST_RB_POP: begin
                if (r_head < r_tail) begin
                    n_state = ST_RB_QW;
                end else begin
                    n_stale = 1'b0;
                    n_x     = r_spos;
                    n_c     = r_item.symbol;
                    n_ret   = RET_TEXT;
                    n_state = ST_ADV_CH;
                end
            end
            ST_RB_QW: begin
                n_u     = q_rd;
                n_from  = CW'(1);
                n_state = ST_RB_SCAN;
            end
            ST_RB_SCAN: begin
                scan_cmd   = '{start: 1'b1, use_sym: 1'b0};
                scan_key_p = r_u;
                scan_from  = r_from;
                n_state    = ST_RB_SW;
            end
            ST_RB_SW: begin
                fail_ra = r_u;
                if (scan_stat.done) begin
                    if (scan_stat.hit) begin
                        n_v    = scan_node;
                        n_c    = scan_node_sym;
                        q_we   = 1'b1;
                        n_tail = r_tail + CW'(1);
                        n_from = CW'(scan_node) + CW'(1);
                        if (r_u == '0) begin
                            // Children of the root fail back to the root.
                            fail_we = 1'b1;
                            fail_wa = scan_node;
                            fail_wd = '0;
                            n_state = ST_RB_SCAN;
                        end else begin
                            n_state = ST_RB_FU;
                        end
                    end else begin
                        n_head  = r_head + CW'(1);
                        n_state = ST_RB_POP;
                    end
                end
            end
            ST_RB_FU: begin
                n_x     = fail_rd;
                n_ret   = RET_REBUILD;
                n_state = ST_ADV_CH;
            end
            ST_ADV_CH: begin
                scan_cmd = '{start: 1'b1, use_sym: 1'b1};
                n_state  = ST_ADV_W;
            end
            ST_ADV_W: begin
                if (scan_stat.done) begin
                    if (scan_stat.hit || r_x == '0) begin
                        if (r_ret == RET_REBUILD) begin
                            fail_we = 1'b1;
                            n_state = ST_RB_SCAN;
                        end else begin
                            n_spos = adv_val;
                            n_j    = adv_val;
                            if (r_tm) begin
                                n_out    = '{match: 1'b0, dropped: 1'b0};
                                n_strobe = 1'b1;
                                n_state  = ST_IDLE;
                                if (r_item.last) begin
                                    n_spos = '0;
                                    n_tm   = 1'b0;
                                end
                            end else begin
                                n_state = ST_MC_CHK;
                            end
                        end
                    end else begin
                        n_state = ST_ADV_F;
                    end
                end
            end
            ST_ADV_F: begin
                n_x     = fail_rd;
                n_state = ST_ADV_CH;
            end
            ST_MC_CHK: begin
                fail_ra = r_j;
                if (r_j == '0) begin
                    n_out    = '{match: 1'b0, dropped: 1'b0};
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_item.last) begin
                        n_spos = '0;
                        n_tm   = 1'b0;
                    end
                end else begin
                    n_state = ST_MC_W;
                end
            end
            ST_MC_W: begin
                if (term_rd) begin
                    n_out    = '{match: 1'b1, dropped: 1'b0};
                    n_strobe = 1'b1;
                    n_tm     = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_item.last) begin
                        n_spos = '0;
                        n_tm   = 1'b0;
                    end
                end else begin
                    n_j     = fail_rd;
                    n_state = ST_MC_CHK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= CW'(1);
            r_ipos   <= '0;
            r_idrop  <= 1'b0;
            r_spos   <= '0;
            r_tm     <= 1'b0;
            r_stale  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ipos   <= n_ipos;
            r_idrop  <= n_idrop;
            r_spos   <= n_spos;
            r_tm     <= n_tm;
            r_stale  <= n_stale;
            r_strobe <= n_strobe;
        end
        r_item <= n_item;
        r_x    <= n_x;
        r_c    <= n_c;
        r_u    <= n_u;
        r_v    <= n_v;
        r_from <= n_from;
        r_head <= n_head;
        r_tail <= n_tail;
        r_ret  <= n_ret;
        r_j    <= n_j;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // A result word never occupies consecutive cycles.
    `MPTM_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)
    // A taken word always keeps the block busy in the next cycle.
    `MPTM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A result never reports a match and a drop together.
    `MPTM_ASSERT(a_result_excl, !(o_strobe && o_result.match && o_result.dropped))
    // The node count stays between the root alone and a full table.
    `MPTM_ASSERT(a_count_range, (r_count != '0) && (r_count <= CW'(NODES)))

endmodule

// ===== bench/multi_pattern_trie_matcher_tb.sv =====
// Self-checking testbench for the multi-pattern trie matcher (Aho-Corasick).
// Depends on mptm_pkg and the multi_pattern_trie_matcher RTL; stands alone.
// A queued driver offers pattern and text words, a trie predictor checks every result.
`timescale 1ns / 1ps

module multi_pattern_trie_matcher_tb;
    import mptm_pkg::*;

    localparam int NODES      = NODES_DEF;
    localparam int CYCLE_CAP  = 40000000;

    // One pending word, with a flag that asks the driver to wait for all
    // outstanding results before offering it.
    typedef struct {
        t_item item;
        bit    drain;
    } t_pending;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_pending pending_words[$];
    t_result  awaited_results[$];
    int       fail_count;
    int       cycle_count;
    int       gap_left;
    bit       calm_stretch;

    // Shadow copy of the trie and both walks.
    int  trie_parent[NODES];
    int  trie_symbol[NODES];
    bit  trie_terminal[NODES];
    int  trie_fail[NODES];
    int  trie_count;
    int  ins_node;
    bit  ins_dropping;
    int  scan_node;
    bit  scan_matched;
    bit  fail_stale;

    // Pool of patterns reused through the random phase, so the trie stays
    // small and each text walk stays short.
    int  pool[12][$];

    multi_pattern_trie_matcher u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int child_node(int p, int c);
        for (int v = 1; v < trie_count; v++) begin
            if (trie_parent[v] == p && trie_symbol[v] == c) begin
                return v;
            end
        end
        return 0;
    endfunction

    // Goto transition, falling back along failure links of shallower nodes.
    function automatic int next_state(int x, int c);
        int ch;
        for (int g = 0; g <= NODES; g++) begin
            ch = child_node(x, c);
            if (ch != 0) begin
                return ch;
            end
            if (x == 0) begin
                return 0;
            end
            x = trie_fail[x];
        end
        return 0;
    endfunction

    // Failure links in breadth-first order, so each parent is done first.
    function automatic void relink_trie();
        int order[$];
        int u;
        trie_fail[0] = 0;
        order.push_back(0);
        while (order.size() > 0) begin
            u = order.pop_front();
            for (int v = 1; v < trie_count; v++) begin
                if (trie_parent[v] == u) begin
                    trie_fail[v] = (u == 0) ? 0 : next_state(trie_fail[u], trie_symbol[v]);
                    order.push_back(v);
                end
            end
        end
        fail_stale = 1'b0;
    endfunction

    function automatic t_result match_outcome(t_item it);
        t_result r;
        int      ch;
        int      j;
        r = '0;
        if (it.op == OP_INSERT) begin
            if (it.first) begin
                ins_node     = 0;
                ins_dropping = 1'b0;
            end
            if (!ins_dropping) begin
                ch = child_node(ins_node, it.symbol);
                if (ch == 0) begin
                    if (trie_count < NODES) begin
                        ch = trie_count;
                        trie_parent[ch]   = ins_node;
                        trie_symbol[ch]   = it.symbol;
                        trie_terminal[ch] = 1'b0;
                        trie_count++;
                        fail_stale = 1'b1;
                    end else begin
                        ins_dropping = 1'b1;
                    end
                end
                if (!ins_dropping) begin
                    ins_node = ch;
                end
            end
            if (ins_dropping) begin
                r.dropped = 1'b1;
            end else if (it.last) begin
                trie_terminal[ins_node] = 1'b1;
            end
            if (it.last) begin
                ins_node     = 0;
                ins_dropping = 1'b0;
            end
        end else begin
            if (it.first) begin
                scan_node    = 0;
                scan_matched = 1'b0;
            end
            if (fail_stale) begin
                relink_trie();
            end
            scan_node = next_state(scan_node, it.symbol);
            // Walk the dictionary-suffix chain; the root never counts.
            if (!scan_matched) begin
                j = scan_node;
                while (j > 0) begin
                    if (trie_terminal[j]) begin
                        r.match      = 1'b1;
                        scan_matched = 1'b1;
                        break;
                    end
                    j = trie_fail[j];
                end
            end
            if (it.last) begin
                scan_node    = 0;
                scan_matched = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic void queue_word(logic op, int sym, bit fst, bit lst, bit drain = 0);
        t_pending p;
        p.item.op     = op;
        p.item.symbol = sym[7:0];
        p.item.first  = fst;
        p.item.last   = lst;
        p.drain       = drain;
        pending_words.push_back(p);
    endfunction

    function automatic void queue_string(logic op, int s[$]);
        for (int k = 0; k < s.size(); k++) begin
            queue_word(op, s[k], k == 0, k == s.size() - 1);
        end
    endfunction

    // Mostly a four-letter alphabet so that texts hit patterns often.
    function automatic int pick_symbol();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(8'h61, 8'h64);
    endfunction

    // Driver: a word is taken at an edge where start is high and busy low.
    always @(posedge i_clk) begin
        bit       taken;
        bit       raise;
        t_pending nxt;
        taken = 1'b0;
        raise = start;
        if (!i_rst_n) begin
            raise = 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                awaited_results.push_back(match_outcome(i_item));
                raise = 1'b0;
            end
            if (!raise) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    nxt = pending_words[0];
                    if (!nxt.drain || (!taken && awaited_results.size() == 0)) begin
                        void'(pending_words.pop_front());
                        i_item <= nxt.item;
                        raise = 1'b1;
                        if ($urandom_range(0, 59) == 0) begin
                            calm_stretch = !calm_stretch;
                        end
                        // Most gaps are short, a few are long.
                        if (!calm_stretch) begin
                            case ($urandom_range(0, 9))
                                0, 1, 2, 3, 4: gap_left = 0;
                                5, 6, 7, 8:    gap_left = $urandom_range(1, 3);
                                default:       gap_left = $urandom_range(10, 40);
                            endcase
                        end
                    end
                end
            end
        end
        start <= raise;
    end

    // Monitor: each strobed result word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result word, actual %b", $time, o_result);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_result.match !== want.match) begin
                    $display("%0t: match mismatch, expected %b actual %b",
                             $time, want.match, o_result.match);
                    fail_count++;
                end
                if (o_result.dropped !== want.dropped) begin
                    $display("%0t: dropped mismatch, expected %b actual %b",
                             $time, want.dropped, o_result.dropped);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int s[$];
        int n;
        int p;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        fail_count   = 0;
        cycle_count  = 0;
        gap_left     = 0;
        calm_stretch = 1'b0;
        trie_count   = 1;
        ins_node     = 0;
        ins_dropping = 1'b0;
        scan_node    = 0;
        scan_matched = 1'b0;
        fail_stale   = 1'b1;
        for (int k = 0; k < NODES; k++) begin
            trie_terminal[k] = 1'b0;
            trie_fail[k]     = 0;
        end

        // Directed part. A text on the bare root, byte extremes, patterns
        // that share suffixes, and a text that walks them through goto and
        // failure links.
        queue_word(OP_SCAN, 8'h61, 1, 1);
        queue_word(OP_INSERT, 8'h00, 1, 1);
        queue_word(OP_INSERT, 8'hFF, 1, 0);
        queue_word(OP_INSERT, 8'hFF, 0, 1);
        queue_string(OP_INSERT, '{8'h61, 8'h62, 8'h63});
        queue_string(OP_INSERT, '{8'h62, 8'h63});
        queue_string(OP_INSERT, '{8'h63, 8'h64});
        queue_string(OP_SCAN, '{8'h00, 8'hFF, 8'h61, 8'h62, 8'h63, 8'h64});
        // A text interrupted by a pattern resumes where it left off.
        queue_word(OP_SCAN, 8'h61, 1, 0);
        queue_word(OP_INSERT, 8'h61, 1, 1);
        queue_word(OP_SCAN, 8'h62, 0, 1);
        // Restart in mid-pattern and a first word that follows no last.
        queue_word(OP_INSERT, 8'h64, 1, 0);
        queue_word(OP_INSERT, 8'h62, 1, 1);
        queue_word(OP_SCAN, 8'h62, 0, 1, 1);

        for (int k = 0; k < 12; k++) begin
            n = $urandom_range(1, 5);
            for (int m = 0; m < n; m++) begin
                pool[k].push_back(pick_symbol());
            end
            queue_string(OP_INSERT, pool[k]);
        end

        // Random part: texts built around pool patterns, reinsertions,
        // the odd new pattern and loose noise words.
        n = 0;
        while (n < 170) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    s = {};
                    repeat ($urandom_range(0, 3)) s.push_back(pick_symbol());
                    p = $urandom_range(0, 11);
                    foreach (pool[p][k]) s.push_back(pool[p][k]);
                    repeat ($urandom_range(0, 3)) s.push_back(pick_symbol());
                    queue_string(OP_SCAN, s);
                    n += s.size();
                end
                12, 13, 14: begin
                    p = $urandom_range(0, 11);
                    queue_string(OP_INSERT, pool[p]);
                    n += pool[p].size();
                end
                15: begin
                    s = {};
                    repeat ($urandom_range(1, 3)) s.push_back(pick_symbol());
                    queue_string(OP_INSERT, s);
                    n += s.size();
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        queue_word($urandom_range(0, 1), $urandom_range(0, 255),
                                   $urandom_range(0, 1), $urandom_range(0, 1));
                        n++;
                    end
                end
            endcase
            if (n % 97 < 3) begin
                pending_words[$].drain = 1'b1;
            end
        end

        // Fill the table with one long fresh chain so that the tail of it
        // is dropped, then check that a later pattern recovers and that a
        // text can still walk the full trie.
        queue_word(OP_INSERT, 8'hF7, 1, 0, 1);
        for (int k = 0; k < 210; k++) begin
            queue_word(OP_INSERT, k[7:0], 0, k == 209);
        end
        queue_string(OP_INSERT, '{8'h61, 8'h62, 8'h63});
        queue_string(OP_INSERT, '{8'h5A, 8'h5B});
        queue_string(OP_SCAN, '{8'hF7, 8'h00, 8'h01, 8'h02, 8'h61, 8'h62, 8'h63});
        queue_string(OP_SCAN, '{8'h64, 8'h61, 8'h62, 8'h63});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || start) @(posedge i_clk);
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
